// ===== design/gha_pkg.sv =====
// Shared package for the generational handle allocator.
// Holds sizes, request/status codes and the pipeline stage types.
// No dependencies.
package gha_pkg;

  localparam int unsigned NumSlots = 256;
  localparam int unsigned SlotW    = $clog2(NumSlots);
  localparam int unsigned CountW   = SlotW + 1;
  localparam int unsigned GenW     = 16;
  localparam int unsigned CtxW     = 8;
  localparam int unsigned OpW      = 2;
  localparam int unsigned StatusW  = 2;

  typedef enum logic [OpW-1:0] {
    OpCreate  = 2'd0,
    OpDestroy = 2'd1,
    OpCheck   = 2'd2,
    OpNone    = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    StOk       = 2'd0,
    StFull     = 2'd1,
    StNotAlloc = 2'd2,
    StNull     = 2'd3
  } status_e;

  // What a request turned into once the counters were consulted.
  typedef enum logic [2:0] {
    KindPop,
    KindNew,
    KindFull,
    KindNull,
    KindNotAlloc,
    KindDestroy,
    KindCheck,
    KindNone
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [SlotW-1:0]  slot;
    logic [GenW-1:0]   gen;
    logic [CtxW-1:0]   ctx;
    logic [CountW-1:0] live;
  } stage_t;

  typedef struct packed {
    logic             valid;
    logic [SlotW-1:0] addr;
    logic [GenW-1:0]  data;
  } gen_wr_t;

endpackage

// ===== design/gha_if.sv =====
// Request and response channel interfaces of the handle allocator.
// Depends on gha_pkg for field widths.
interface gha_req_if;
  logic                      valid;
  logic                      ready;
  logic [gha_pkg::OpW-1:0]   op;
  logic [gha_pkg::CtxW-1:0]  context_tag;
  logic [gha_pkg::SlotW-1:0] entity_index;
  logic [gha_pkg::GenW-1:0]  entity_generation;

  modport source (output valid, op, context_tag, entity_index, entity_generation,
                  input ready);
  modport sink (input valid, op, context_tag, entity_index, entity_generation,
                output ready);
endinterface

interface gha_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [gha_pkg::SlotW-1:0]   handle_index;
  logic [gha_pkg::GenW-1:0]    handle_generation;
  logic [gha_pkg::CtxW-1:0]    handle_context;
  logic                        is_valid;
  logic [gha_pkg::StatusW-1:0] status;
  logic [gha_pkg::CountW-1:0]  live_count;

  modport source (output valid, handle_index, handle_generation, handle_context,
                  is_valid, status, live_count, input ready);
  modport sink (input valid, handle_index, handle_generation, handle_context,
                is_valid, status, live_count, output ready);
endinterface

// ===== design/generational_handle_allocator.sv =====
// Generational handle allocator, top level.
// Depends on gha_pkg, gha_if (gha_req_if, gha_rsp_if) and gha_ram.

// Takes one request per cycle while no response waits, and returns one response
// per request, in order. The free-stack read, the generation-table read and the
// response register lie in that order between a request's acceptance and its
// response. The first two are the registered memory reads that a create from
// the free stack needs back to back: first the stacked slot index, then that
// slot's generation. The counters (stack depth, slots used, live count) are
// updated at the accept edge, so status decisions never wait on memory. A
// generation-table write lands on the same edge as the next request's read,
// which still returns the old value, so a one-entry bypass register covers
// that case. Both tables come up undefined and need no clearing pass after
// reset; only values from entries already written are ever used. While a
// response waits, the whole pipeline holds, and req ready drops only then.
module generational_handle_allocator (
  input  logic           clk_i,
  input  logic           rst_ni,
  gha_req_if.sink        req_i,
  gha_rsp_if.source      rsp_o
);

  localparam int unsigned SlotW   = gha_pkg::SlotW;
  localparam int unsigned CountW  = gha_pkg::CountW;
  localparam int unsigned GenW    = gha_pkg::GenW;
  localparam int unsigned CtxW    = gha_pkg::CtxW;

  // ---------------------------------------------------------------------------
  // Pipeline control: everything moves together when the response slot frees.
  // ---------------------------------------------------------------------------
  logic advance;
  logic accept;
  logic v1_q, v2_q, out_valid_q;

  assign advance     = !out_valid_q || rsp_o.ready;
  assign req_i.ready = advance;
  assign accept      = req_i.valid && advance;

  // Allocator counters
  logic [CountW-1:0] depth_q, depth_d;
  logic [CountW-1:0] used_q, used_d;
  logic [CountW-1:0] live_q, live_d;

  // Stage registers
  gha_pkg::stage_t   s0, s1_q, s2_d, s2_q;
  gha_pkg::gen_wr_t  gen_wr_d, gen_wr_q;

  // Memory ports
  logic              stk_we;
  logic [SlotW-1:0]  stk_waddr, stk_raddr, stk_rdata;
  logic [SlotW-1:0]  gen_raddr;
  logic [GenW-1:0]   gen_rdata;

  // Stage 0 helpers
  logic [CountW-1:0] idx_ext;
  logic [CountW-1:0] depth_m1;

  assign idx_ext   = {1'b0, req_i.entity_index};
  assign depth_m1  = depth_q - CountW'(1);
  assign stk_raddr = depth_m1[SlotW-1:0];
  assign stk_waddr = depth_q[SlotW-1:0];

  // ---------------------------------------------------------------------------
  // Stage 0: classify the request against the counters, push on destroy unless full.
  // ---------------------------------------------------------------------------
  always_comb begin
    depth_d  = depth_q;
    used_d   = used_q;
    live_d   = live_q;
    stk_we   = 1'b0;
    s0.kind  = gha_pkg::KindNone;
    s0.slot  = req_i.entity_index;
    s0.gen   = req_i.entity_generation;
    s0.ctx   = req_i.context_tag;
    if (accept) begin
      unique case (gha_pkg::op_e'(req_i.op))
        gha_pkg::OpCreate: begin
          if (depth_q != '0) begin
            // reuse the most recently freed slot
            s0.kind = gha_pkg::KindPop;
            depth_d = depth_m1;
          end else if (used_q < CountW'(gha_pkg::NumSlots)) begin
            // first use of a slot: generation starts at 1
            s0.kind = gha_pkg::KindNew;
            s0.slot = used_q[SlotW-1:0];
            used_d  = used_q + CountW'(1);
          end else begin
            s0.kind = gha_pkg::KindFull;
          end
          if (s0.kind != gha_pkg::KindFull &&
              live_q < CountW'(gha_pkg::NumSlots)) begin
            live_d = live_q + CountW'(1);
          end
        end
        gha_pkg::OpDestroy: begin
          if (req_i.entity_index == '0 && req_i.entity_generation == '0) begin
            s0.kind = gha_pkg::KindNull;
          end else if (idx_ext >= used_q) begin
            s0.kind = gha_pkg::KindNotAlloc;
          end else begin
            // no generation compare: a stale destroy still bumps the slot
            s0.kind = gha_pkg::KindDestroy;
            if (depth_q < CountW'(gha_pkg::NumSlots)) begin
              stk_we  = 1'b1;
              depth_d = depth_q + CountW'(1);
            end
            if (live_q != '0) begin
              live_d = live_q - CountW'(1);
            end
          end
        end
        gha_pkg::OpCheck: begin
          if (idx_ext >= used_q) begin
            s0.kind = gha_pkg::KindNotAlloc;
          end else begin
            s0.kind = gha_pkg::KindCheck;
          end
        end
        gha_pkg::OpNone: begin
          s0.kind = gha_pkg::KindNone;
        end
      endcase
    end
    s0.live = live_d;
  end

  gha_ram #(
    .WIDTH (SlotW),
    .DEPTH (gha_pkg::NumSlots)
  ) u_free_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (req_i.entity_index),
    .re_i    (advance),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  // ---------------------------------------------------------------------------
  // Stage 1: resolve the slot (popped index or request index), read its gen.
  // ---------------------------------------------------------------------------
  always_comb begin
    gen_raddr = (s1_q.kind == gha_pkg::KindPop) ? stk_rdata : s1_q.slot;
    s2_d      = s1_q;
    s2_d.slot = gen_raddr;
  end

  gha_ram #(
    .WIDTH (GenW),
    .DEPTH (gha_pkg::NumSlots)
  ) u_gen_table (
    .clk_i   (clk_i),
    .we_i    (gen_wr_d.valid && advance),
    .waddr_i (gen_wr_d.addr),
    .wdata_i (gen_wr_d.data),
    .re_i    (advance),
    .raddr_i (gen_raddr),
    .rdata_o (gen_rdata)
  );

  // ---------------------------------------------------------------------------
  // Stage 2: bypass the previous write, build the response, update the table.
  // ---------------------------------------------------------------------------
  logic [GenW-1:0]             gen_cur, gen_inc;
  logic [SlotW-1:0]            res_index;
  logic [GenW-1:0]             res_gen;
  logic [CtxW-1:0]             res_ctx;
  logic                        res_valid;
  gha_pkg::status_e            res_status;

  assign gen_cur = (gen_wr_q.valid && gen_wr_q.addr == s2_q.slot) ? gen_wr_q.data
                                                                  : gen_rdata;
  // wrap past the top to 1, never 0
  assign gen_inc = (gen_cur + GenW'(1) == '0) ? GenW'(1) : gen_cur + GenW'(1);

  always_comb begin
    res_index      = s2_q.slot;
    res_gen        = '0;
    res_ctx        = '0;
    res_valid      = 1'b0;
    res_status     = gha_pkg::StOk;
    gen_wr_d.valid = 1'b0;
    gen_wr_d.addr  = s2_q.slot;
    gen_wr_d.data  = gen_inc;
    unique case (s2_q.kind)
      gha_pkg::KindPop: begin
        res_gen = gen_cur;
        res_ctx = s2_q.ctx;
      end
      gha_pkg::KindNew: begin
        res_gen        = GenW'(1);
        res_ctx        = s2_q.ctx;
        gen_wr_d.valid = v2_q;
        gen_wr_d.data  = GenW'(1);
      end
      gha_pkg::KindFull: begin
        res_index  = '0;
        res_status = gha_pkg::StFull;
      end
      gha_pkg::KindNull: begin
        res_status = gha_pkg::StNull;
      end
      gha_pkg::KindNotAlloc: begin
        res_status = gha_pkg::StNotAlloc;
      end
      gha_pkg::KindDestroy: begin
        res_gen        = gen_inc;
        gen_wr_d.valid = v2_q;
      end
      gha_pkg::KindCheck: begin
        res_gen   = gen_cur;
        res_valid = (gen_cur == s2_q.gen);
      end
      gha_pkg::KindNone: begin
        res_status = gha_pkg::StOk;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q           <= 1'b0;
      v2_q           <= 1'b0;
      out_valid_q    <= 1'b0;
      depth_q        <= '0;
      used_q         <= '0;
      live_q         <= '0;
      gen_wr_q       <= '0;
    end else if (advance) begin
      v1_q           <= accept;
      v2_q           <= v1_q;
      out_valid_q    <= v2_q;
      depth_q        <= depth_d;
      used_q         <= used_d;
      live_q         <= live_d;
      gen_wr_q       <= gen_wr_d;
    end
  end

  logic [SlotW-1:0]           rsp_index_q;
  logic [GenW-1:0]            rsp_gen_q;
  logic [CtxW-1:0]            rsp_ctx_q;
  logic                       rsp_is_valid_q;
  logic [gha_pkg::StatusW-1:0] rsp_status_q;
  logic [CountW-1:0]          rsp_live_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_q           <= s0;
      s2_q           <= s2_d;
      rsp_index_q    <= res_index;
      rsp_gen_q      <= res_gen;
      rsp_ctx_q      <= res_ctx;
      rsp_is_valid_q <= res_valid;
      rsp_status_q   <= res_status;
      rsp_live_q     <= s2_q.live;
    end
  end

  assign rsp_o.valid             = out_valid_q;
  assign rsp_o.handle_index      = rsp_index_q;
  assign rsp_o.handle_generation = rsp_gen_q;
  assign rsp_o.handle_context    = rsp_ctx_q;
  assign rsp_o.is_valid          = rsp_is_valid_q;
  assign rsp_o.status            = rsp_status_q;
  assign rsp_o.live_count        = rsp_live_q;

endmodule

// ===== design/gha_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// Read returns the old contents on a same-address write. No dependencies.
module gha_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== dv/generational_handle_allocator_tb.sv =====
// Self-checking testbench for the generational handle allocator.
// Drives requests through gha_req_if, checks responses on gha_rsp_if against
// an in-bench allocator model. Depends on gha_pkg, gha_if and the design.
module generational_handle_allocator_tb;

  localparam int TimeoutCycles = 500000;
  localparam int HoldOffCycles = 48;

  typedef struct packed {
    logic [gha_pkg::OpW-1:0]   op;
    logic [gha_pkg::CtxW-1:0]  ctx;
    logic [gha_pkg::SlotW-1:0] idx;
    logic [gha_pkg::GenW-1:0]  gen;
  } handle_req_t;

  typedef struct packed {
    logic [gha_pkg::SlotW-1:0]   index;
    logic [gha_pkg::GenW-1:0]    gen;
    logic [gha_pkg::CtxW-1:0]    ctx;
    logic                        valid;
    logic [gha_pkg::StatusW-1:0] status;
    logic [gha_pkg::CountW-1:0]  live;
  } handle_rsp_t;

  // Directed request; the response is typed in only where it is obvious.
  typedef struct packed {
    logic        typed;
    handle_req_t req;
    handle_rsp_t want;
  } dir_row_t;

  localparam dir_row_t DirRows [24] = '{
    // empty table: error codes and the unknown op
    '{1'b1, '{gha_pkg::OpCheck,   8'h00, 8'h00, 16'h0000},
            '{8'h00, 16'h0000, 8'h00, 1'b0, gha_pkg::StNotAlloc, 9'd0}},
    '{1'b1, '{gha_pkg::OpDestroy, 8'h00, 8'h00, 16'h0000},
            '{8'h00, 16'h0000, 8'h00, 1'b0, gha_pkg::StNull, 9'd0}},
    '{1'b1, '{gha_pkg::OpDestroy, 8'h00, 8'hff, 16'hffff},
            '{8'hff, 16'h0000, 8'h00, 1'b0, gha_pkg::StNotAlloc, 9'd0}},
    '{1'b1, '{gha_pkg::OpNone,    8'hff, 8'hff, 16'hffff},
            '{8'hff, 16'h0000, 8'h00, 1'b0, gha_pkg::StOk, 9'd0}},
    // fresh slots come up at generation 1
    '{1'b1, '{gha_pkg::OpCreate,  8'hff, 8'h00, 16'h0000},
            '{8'h00, 16'h0001, 8'hff, 1'b0, gha_pkg::StOk, 9'd1}},
    '{1'b1, '{gha_pkg::OpCreate,  8'h00, 8'hff, 16'hffff},
            '{8'h01, 16'h0001, 8'h00, 1'b0, gha_pkg::StOk, 9'd2}},
    '{1'b1, '{gha_pkg::OpCreate,  8'ha5, 8'h00, 16'h0000},
            '{8'h02, 16'h0001, 8'ha5, 1'b0, gha_pkg::StOk, 9'd3}},
    '{1'b1, '{gha_pkg::OpCheck,   8'h00, 8'h01, 16'h0001},
            '{8'h01, 16'h0001, 8'h00, 1'b1, gha_pkg::StOk, 9'd3}},
    '{1'b1, '{gha_pkg::OpCheck,   8'hff, 8'h01, 16'hffff},
            '{8'h01, 16'h0001, 8'h00, 1'b0, gha_pkg::StOk, 9'd3}},
    '{1'b0, '{gha_pkg::OpCheck,   8'h00, 8'h02, 16'h0000}, '0},
    // first index past the used slots, and the top index
    '{1'b1, '{gha_pkg::OpCheck,   8'h00, 8'h03, 16'h0001},
            '{8'h03, 16'h0000, 8'h00, 1'b0, gha_pkg::StNotAlloc, 9'd3}},
    '{1'b1, '{gha_pkg::OpCheck,   8'h00, 8'hff, 16'hffff},
            '{8'hff, 16'h0000, 8'h00, 1'b0, gha_pkg::StNotAlloc, 9'd3}},
    // stale destroy still bumps; both copies come back off the stack
    '{1'b0, '{gha_pkg::OpDestroy, 8'h00, 8'h01, 16'h0001}, '0},
    '{1'b0, '{gha_pkg::OpDestroy, 8'h00, 8'h01, 16'h0001}, '0},
    '{1'b0, '{gha_pkg::OpCheck,   8'h00, 8'h01, 16'h0002}, '0},
    '{1'b0, '{gha_pkg::OpCreate,  8'h3c, 8'h00, 16'h0000}, '0},
    '{1'b0, '{gha_pkg::OpCreate,  8'hc3, 8'h00, 16'h0000}, '0},
    // index 0 is only null together with generation 0
    '{1'b0, '{gha_pkg::OpDestroy, 8'h00, 8'h00, 16'h0001}, '0},
    '{1'b1, '{gha_pkg::OpDestroy, 8'h00, 8'h00, 16'h0000},
            '{8'h00, 16'h0000, 8'h00, 1'b0, gha_pkg::StNull, 9'd2}},
    '{1'b0, '{gha_pkg::OpCreate,  8'h5a, 8'h00, 16'h0000}, '0},
    '{1'b0, '{gha_pkg::OpDestroy, 8'h00, 8'h02, 16'hffff}, '0},
    '{1'b0, '{gha_pkg::OpCheck,   8'h00, 8'h00, 16'h0002}, '0},
    '{1'b0, '{gha_pkg::OpCreate,  8'h81, 8'h00, 16'h0000}, '0},
    '{1'b1, '{gha_pkg::OpNone,    8'h00, 8'h00, 16'h0000},
            '{8'h00, 16'h0000, 8'h00, 1'b0, gha_pkg::StOk, 9'd3}}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  gha_req_if req_bus ();
  gha_rsp_if rsp_bus ();

  generational_handle_allocator DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Allocator model state
  logic [gha_pkg::GenW-1:0]  gen_table  [gha_pkg::NumSlots];
  logic [gha_pkg::SlotW-1:0] free_stack [gha_pkg::NumSlots];
  int unsigned stack_depth = 0;
  int unsigned slots_used  = 0;
  int unsigned live_total  = 0;

  handle_rsp_t expected_rsps [$];
  bit          cur_typed = 1'b0;
  handle_rsp_t cur_want  = '0;
  int          mismatches = 0;

  // What the run went through
  int op_count [4] = '{0, 0, 0, 0};
  int n_full = 0, n_null = 0, n_notalloc = 0, n_wrap = 0, n_drop = 0, n_live_sat = 0;

  int send_idle_pct = 0;
  int rsp_stall_pct = 0;
  int hold_requests = 0;

  function automatic handle_rsp_t predict_handle_op(handle_req_t r);
    handle_rsp_t o;
    logic [gha_pkg::SlotW-1:0] slot;
    logic [gha_pkg::GenW-1:0] g;
    bit placed;
    o = '0;
    slot = '0;
    placed = 1'b1;
    op_count[r.op]++;
    case (r.op)
      gha_pkg::OpCreate: begin
        if (stack_depth > 0) begin
          stack_depth--;
          slot = free_stack[stack_depth];
        end else if (slots_used < gha_pkg::NumSlots) begin
          slot = gha_pkg::SlotW'(slots_used);
          gen_table[slot] = gha_pkg::GenW'(1);
          slots_used++;
        end else begin
          placed = 1'b0;
          o.status = gha_pkg::StFull;
          n_full++;
        end
        if (placed) begin
          if (live_total < gha_pkg::NumSlots) live_total++;
          else n_live_sat++;
          o.index = slot;
          o.gen   = gen_table[slot];
          o.ctx   = r.ctx;
        end
      end
      gha_pkg::OpDestroy: begin
        o.index = r.idx;
        if (r.idx == '0 && r.gen == '0) begin
          o.status = gha_pkg::StNull;
          n_null++;
        end else if (r.idx >= slots_used) begin
          o.status = gha_pkg::StNotAlloc;
          n_notalloc++;
        end else begin
          // generation 0 is reserved, so the wrap lands on 1
          g = gen_table[r.idx] + 1'b1;
          if (g == '0) begin
            g = gha_pkg::GenW'(1);
            n_wrap++;
          end
          gen_table[r.idx] = g;
          if (stack_depth < gha_pkg::NumSlots) begin
            free_stack[stack_depth] = r.idx;
            stack_depth++;
          end else begin
            n_drop++;
          end
          if (live_total > 0) live_total--;
          o.gen = g;
        end
      end
      gha_pkg::OpCheck: begin
        o.index = r.idx;
        if (r.idx >= slots_used) begin
          o.status = gha_pkg::StNotAlloc;
          n_notalloc++;
        end else begin
          o.gen   = gen_table[r.idx];
          o.valid = (gen_table[r.idx] == r.gen);
        end
      end
      default: o.index = r.idx;
    endcase
    o.live = gha_pkg::CountW'(live_total);
    return o;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Accepted requests feed the model; accepted responses pop the oldest expectation.
  always @(posedge clk_i) begin : scoreboard
    handle_rsp_t want;
    if (rst_ni) begin
      if (req_bus.valid && req_bus.ready) begin
        want = predict_handle_op({req_bus.op, req_bus.context_tag, req_bus.entity_index,
                                  req_bus.entity_generation});
        if (cur_typed) want = cur_want;
        expected_rsps = {expected_rsps, want};
      end
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (expected_rsps.size() == 0) begin
          $error("response with nothing outstanding (index 0x%0h)", rsp_bus.handle_index);
          mismatches++;
        end else begin
          want = expected_rsps.pop_front();
          check_field("handle_index", 32'(want.index), 32'(rsp_bus.handle_index));
          check_field("handle_generation", 32'(want.gen), 32'(rsp_bus.handle_generation));
          check_field("handle_context", 32'(want.ctx), 32'(rsp_bus.handle_context));
          check_field("is_valid", 32'(want.valid), 32'(rsp_bus.is_valid));
          check_field("status", 32'(want.status), 32'(rsp_bus.status));
          check_field("live_count", 32'(want.live), 32'(rsp_bus.live_count));
        end
      end
    end
  end

  // Response side: random stalls, plus a long hold-off whenever one is asked for.
  initial begin : rsp_sink
    int served;
    int hold_left;
    served = 0;
    hold_left = 0;
    rsp_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_requests != served) begin
        served = hold_requests;
        hold_left = HoldOffCycles;
      end
      if (hold_left > 0) begin
        rsp_bus.ready = 1'b0;
        hold_left--;
      end else begin
        rsp_bus.ready = ($urandom_range(0, 99) >= rsp_stall_pct);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(handle_req_t r, bit typed, handle_rsp_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_bus.valid = 1'b0;
      @(negedge clk_i);
    end
    cur_typed = typed;
    cur_want = want;
    req_bus.op = r.op;
    req_bus.context_tag = r.ctx;
    req_bus.entity_index = r.idx;
    req_bus.entity_generation = r.gen;
    req_bus.valid = 1'b1;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    req_bus.valid = 1'b0;
    while (expected_rsps.size() != 0) @(negedge clk_i);
  endtask

  // Mostly handles of used slots at their live generation; some stale, some noise.
  function automatic handle_req_t aim_at_slot(logic [gha_pkg::OpW-1:0] op);
    handle_req_t r;
    int unsigned pick;
    r.op = op;
    r.ctx = gha_pkg::CtxW'($urandom);
    pick = $urandom_range(0, 99);
    if (slots_used == 0 || pick >= 90) begin
      r.idx = gha_pkg::SlotW'($urandom);
      r.gen = gha_pkg::GenW'($urandom);
    end else begin
      r.idx = gha_pkg::SlotW'($urandom_range(0, slots_used - 1));
      if (pick < 70) r.gen = gen_table[r.idx];
      else if (pick < 80) r.gen = gen_table[r.idx] - 1'b1;
      else r.gen = gha_pkg::GenW'($urandom);
    end
    return r;
  endfunction

  task automatic run_mixed(int count);
    handle_req_t r;
    int unsigned pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) r = aim_at_slot(gha_pkg::OpCreate);
      else if (pick < 62) r = aim_at_slot(gha_pkg::OpDestroy);
      else if (pick < 90) r = aim_at_slot(gha_pkg::OpCheck);
      else if (pick < 95) r = aim_at_slot(gha_pkg::OpNone);
      else begin
        r = aim_at_slot(gha_pkg::OpDestroy);
        r.idx = '0;
        r.gen = '0;
      end
      send_request(r, 1'b0, '0);
    end
  endtask

  initial begin : stimulus
    handle_req_t r;
    int row;
    int full_mark;
    int drop_mark;
    rst_ni = 1'b0;
    req_bus.valid = 1'b0;
    req_bus.op = gha_pkg::OpNone;
    req_bus.context_tag = '0;
    req_bus.entity_index = '0;
    req_bus.entity_generation = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (row = 0; row < $size(DirRows); row++)
      send_request(DirRows[row].req, DirRows[row].typed, DirRows[row].want);

    // Back to back, no idling on either side
    run_mixed(40);
    wait_drained();

    // Create until every slot is used and the table reports full; the free
    // stack is emptied on the way.
    send_idle_pct = 63;
    full_mark = n_full;
    while (n_full < full_mark + 4) begin
      r = ($urandom_range(0, 9) == 0) ? aim_at_slot(gha_pkg::OpCheck)
                                      : aim_at_slot(gha_pkg::OpCreate);
      send_request(r, 1'b0, '0);
    end
    wait_drained();

    // Destroy until the free stack overflows and the live count runs to zero;
    // long hold-off up front backs the pipe up into the request side.
    send_idle_pct = 0;
    rsp_stall_pct = 63;
    hold_requests++;
    drop_mark = n_drop;
    while (n_drop < drop_mark + 3) begin
      r = ($urandom_range(0, 9) == 0) ? aim_at_slot(gha_pkg::OpCheck)
                                      : aim_at_slot(gha_pkg::OpDestroy);
      send_request(r, 1'b0, '0);
    end
    wait_drained();

    send_idle_pct = 9;
    rsp_stall_pct = 9;
    run_mixed(30);
    wait_drained();
    repeat (8) @(posedge clk_i);

    $display("Ran %0d create, %0d destroy, %0d check, %0d unknown-op requests.",
             op_count[gha_pkg::OpCreate], op_count[gha_pkg::OpDestroy],
             op_count[gha_pkg::OpCheck], op_count[gha_pkg::OpNone]);
    $display("Saw %0d full, %0d null, %0d not-allocated; %0d wraps,",
             n_full, n_null, n_notalloc, n_wrap);
    $display("%0d dropped pushes, %0d live caps.", n_drop, n_live_sat);
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("generational_handle_allocator_tb: done, clean");
    end else begin
      $display("generational_handle_allocator_tb: done, errors");
    end
    $finish;
  end

  initial begin : watchdog
    repeat (TimeoutCycles) @(posedge clk_i);
    $display("generational_handle_allocator_tb: done, errors");
    $finish;
  end

endmodule
